### hdl/bb3_pkg.sv
// Shared types and constants for the edge-aware 3x3 box blur.
// Used by the controller, the datapath and the top level.
`default_nettype none
package bb3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int OUT_COL_W = 10;
   localparam int ROW_W     = 16;
   localparam int FW_W      = 11;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int LS_DEPTH  = 3 * MAX_WIDTH;
   localparam int LS_AW     = $clog2(LS_DEPTH);
   localparam int SUM_W     = 12;
   localparam int CNT_W     = 4;
   localparam int DIVD_W    = 13;
   localparam int DIVR_W    = 5;
   localparam int REM_W     = 6;
   localparam int DIV_STEPS = DIVD_W;
   localparam int DCNT_W    = 4;
   localparam int JOB_W     = 2;
   localparam int NUM_JOBS  = 4;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int RSP_DW    = 56;

   localparam logic [FW_W-1:0]  FW_RESET = FW_W'(1024);
   localparam logic [ROW_W-1:0] FH_RESET = ROW_W'(768);

   // Register indexes (paddr[2]).
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic             accept;
      logic             start;
      logic             tap;
      logic             div_start;
      logic             div_step;
      logic             load_out;
      logic [JOB_W-1:0] job;
   } cmd_type;

   typedef struct packed {
      logic [NUM_JOBS-1:0] job_valid;
      logic                tap_last;
      logic                div_last;
   } status_type;

   typedef struct packed {
      logic              wr;
      logic              index;
      logic [CSR_DW-1:0] data;
   } csr_wr_type;

endpackage
`default_nettype wire

### hdl/bb3_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 3072
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### hdl/bb3_dp.sv
// Datapath of the box blur: configuration, positions, line store,
// neighbourhood accumulation, rounding divider and result register.
// Depends on bb3_pkg and bb3_ram.
`default_nettype none
module bb3_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bb3_pkg::cmd_type        cmd,
   output bb3_pkg::status_type          status,
   input  wire bb3_pkg::csr_wr_type     csr_wr,
   output logic [bb3_pkg::FW_W-1:0]     frame_width,
   output logic [bb3_pkg::ROW_W-1:0]    frame_height,
   input  wire logic [bb3_pkg::PIX_W-1:0] pixel,
   output logic [bb3_pkg::RSP_DW-1:0]   rsp_data,
   output logic                         rsp_last
);
   import bb3_pkg::*;

   function automatic logic [1:0] mod3(input logic [2:0] v);
      logic [1:0] m;
      case (v)
         3'd0, 3'd3, 3'd6: m = 2'd0;
         3'd1, 3'd4, 3'd7: m = 2'd1;
         default:          m = 2'd2;
      endcase
      return m;
   endfunction

   logic [FW_W-1:0]  fw_ff;
   logic [ROW_W-1:0] fh_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       rm_ff, rm_in;
   logic [FW_W-1:0]  w;
   logic [ROW_W-1:0] h;

   logic [ROW_W-1:0] r;
   logic [COL_W-1:0] c;
   logic [1:0]       rm;
   logic             last_row;
   logic             col_last;

   logic [ROW_W-1:0] cur_r_ff;
   logic [COL_W-1:0] cur_c_ff;
   logic [1:0]       cur_rm_ff;
   logic [NUM_JOBS-1:0] jobs_ff;

   logic [ROW_W-1:0] e_ff;
   logic [COL_W-1:0] ec_ff;
   logic [1:0]       erm_ff;
   logic [1:0]       dy_ff, dx_ff;
   logic             rd_valid_ff;
   logic [SUM_W-1:0] sum_ff [3];
   logic [CNT_W-1:0] cnt_ff;

   logic             y_ok, x_ok, in_frame;
   logic [COL_W-1:0] nx;
   logic [1:0]       nrm;
   logic [LS_AW-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;

   logic [DIVD_W-1:0] x_ff [3];
   logic [DIVD_W-1:0] q_ff [3];
   logic [REM_W-1:0]  rem_ff [3];
   logic [DIVR_W-1:0] dvsr_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   logic [CH_W-1:0]      out_ch_ff [3];
   logic [ROW_W-1:0]     out_row_ff;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic                 out_done_ff;

   assign w = (fw_ff == '0) ? FW_W'(1) :
              (fw_ff > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_ff;
   assign h = (fh_ff == '0) ? ROW_W'(1) : fh_ff;
   assign frame_width  = fw_ff;
   assign frame_height = fh_ff;

   // A stale position beyond the frame restarts at the origin.
   always_comb begin
      if (row_ff >= h || FW_W'(col_ff) >= w) begin
         r  = '0;
         c  = '0;
         rm = 2'd0;
      end else begin
         r  = row_ff;
         c  = col_ff;
         rm = rm_ff;
      end
      last_row = (r == h - ROW_W'(1));
      col_last = (FW_W'(c) == w - FW_W'(1));
      row_in = r;
      rm_in  = rm;
      if (col_last) begin
         col_in = '0;
         if (last_row) begin
            row_in = '0;
            rm_in  = 2'd0;
         end else begin
            row_in = r + ROW_W'(1);
            rm_in  = (rm == 2'd2) ? 2'd0 : rm + 2'd1;
         end
      end else begin
         col_in = c + COL_W'(1);
      end
   end

   always_comb begin
      unique case (dy_ff)
         2'd0:    y_ok = (e_ff != '0);
         2'd2:    y_ok = ({1'b0, e_ff} + 17'd1) < {1'b0, h};
         default: y_ok = 1'b1;
      endcase
      unique case (dx_ff)
         2'd0:    x_ok = (ec_ff != '0);
         2'd2:    x_ok = (FW_W'(ec_ff) + FW_W'(1)) < w;
         default: x_ok = 1'b1;
      endcase
      in_frame = y_ok && x_ok;
      nx  = ec_ff + COL_W'(dx_ff) - COL_W'(1);
      nrm = mod3({1'b0, erm_ff} + {1'b0, dy_ff} + 3'd2);
   end

   assign wr_addr = LS_AW'(rm) * LS_AW'(MAX_WIDTH) + LS_AW'(c);
   assign rd_addr = LS_AW'(nrm) * LS_AW'(MAX_WIDTH) + LS_AW'(nx);

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (pixel),
      .rd_en   (cmd.tap),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.job_valid = jobs_ff;
   assign status.tap_last  = (dy_ff == 2'd2) && (dx_ff == 2'd2);
   assign status.div_last  = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= FW_RESET;
         fh_ff       <= FH_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         rm_ff       <= 2'd0;
         rd_valid_ff <= 1'b0;
         jobs_ff     <= '0;
      end else begin
         rd_valid_ff <= cmd.tap && in_frame;
         if (csr_wr.wr) begin
            if (csr_wr.index == REG_FRAME_WIDTH) begin
               fw_ff <= csr_wr.data[FW_W-1:0];
            end else begin
               fh_ff <= csr_wr.data[ROW_W-1:0];
            end
            row_ff <= '0;
            col_ff <= '0;
            rm_ff  <= 2'd0;
         end else if (cmd.accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            rm_ff  <= rm_in;
         end
         if (cmd.accept) begin
            // Result order: column c-1 (row above, then this row),
            // then column c on the last column.
            jobs_ff[0] <= (c != '0) && (r != '0);
            jobs_ff[1] <= (c != '0) && last_row;
            jobs_ff[2] <= col_last && (r != '0);
            jobs_ff[3] <= col_last && last_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_r_ff  <= r;
         cur_c_ff  <= c;
         cur_rm_ff <= rm;
      end
      if (cmd.start) begin
         e_ff   <= cmd.job[0] ? cur_r_ff : cur_r_ff - ROW_W'(1);
         ec_ff  <= cmd.job[1] ? cur_c_ff : cur_c_ff - COL_W'(1);
         erm_ff <= cmd.job[0] ? cur_rm_ff : mod3({1'b0, cur_rm_ff} + 3'd2);
         dy_ff  <= 2'd0;
         dx_ff  <= 2'd0;
         cnt_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (cmd.tap) begin
            if (dx_ff == 2'd2) begin
               dx_ff <= 2'd0;
               dy_ff <= dy_ff + 2'd1;
            end else begin
               dx_ff <= dx_ff + 2'd1;
            end
         end
         if (rd_valid_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(rd_data[i*CH_W +: CH_W]);
            end
         end
      end
   end

   // Restoring division of (2*sum + count) by 2*count, one bit a cycle.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvsr_ff <= {cnt_ff, 1'b0};
         dcnt_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            x_ff[i]   <= {sum_ff[i], 1'b0} + DIVD_W'(cnt_ff);
            q_ff[i]   <= '0;
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
         for (int i = 0; i < 3; i++) begin
            if ({rem_ff[i][REM_W-2:0], x_ff[i][DIVD_W-1]} >= REM_W'(dvsr_ff)) begin
               rem_ff[i] <= {rem_ff[i][REM_W-2:0], x_ff[i][DIVD_W-1]} - REM_W'(dvsr_ff);
               q_ff[i]   <= {q_ff[i][DIVD_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= {rem_ff[i][REM_W-2:0], x_ff[i][DIVD_W-1]};
               q_ff[i]   <= {q_ff[i][DIVD_W-2:0], 1'b0};
            end
            x_ff[i] <= {x_ff[i][DIVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         for (int i = 0; i < 3; i++) begin
            out_ch_ff[i] <= q_ff[i][CH_W-1:0];
         end
         out_row_ff  <= e_ff;
         out_col_ff  <= OUT_COL_W'(ec_ff);
         out_done_ff <= (e_ff == h - ROW_W'(1)) && (FW_W'(ec_ff) == w - FW_W'(1));
      end
   end

   assign rsp_data = RSP_DW'({out_col_ff, out_row_ff, out_ch_ff[2], out_ch_ff[1],
                              out_ch_ff[0]});
   assign rsp_last = out_done_ff;
endmodule
`default_nettype wire

### hdl/bb3_ctrl.sv
// Controller of the box blur: walks the up-to-four results of a request
// through neighbourhood read, division and output. Depends on bb3_pkg.
`default_nettype none
module bb3_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output bb3_pkg::cmd_type        cmd,
   input  wire bb3_pkg::status_type status
);
   import bb3_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_TAP, ST_DRAIN, ST_LOAD, ST_DIV, ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [JOB_W-1:0] job_ff, job_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.job      = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               job_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.job_valid[job_ff]) begin
               cmd.start = 1'b1;
               state_in  = ST_TAP;
            end else if (job_ff == JOB_W'(NUM_JOBS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               job_in = job_ff + JOB_W'(1);
            end
         end
         ST_TAP: begin
            cmd.tap = 1'b1;
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_LOAD;
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (job_ff == JOB_W'(NUM_JOBS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  job_in   = job_ff + JOB_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while still pending");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN && job_ff == '0))
      else $error("accepted request did not start the result scan");

   a_div_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_EMIT))
      else $error("division finished without moving to output");
endmodule
`default_nettype wire

### hdl/box_blur_3x3_edge_aware_top.sv
// Top level of the edge-aware 3x3 box blur.
// Depends on bb3_pkg, bb3_ctrl, bb3_dp and bb3_ram.
//
// Pixels enter in raster order on the req_ stream, one request per pixel.
// Each request writes the pixel into a three-row line store and then yields
// zero to four blurred results on the rsp_ stream, for every pixel whose
// lower-right in-frame neighbour has just arrived; on the last row the
// results of the last two rows interleave, column by column.
// Each result reads its neighbourhood from the single line-store read port,
// one neighbour a cycle, then divides all three channels at once in a
// bit-serial divider.
// The result register decouples the two sides: a new request is taken while
// the last result still waits; if the receiver stalls, the block holds its
// next result and stops there until the register drains.
// Reset sets frame_width to 1024, frame_height to 768 and the position to the
// frame origin. Any write on the csr_ port also restarts the frame; the
// store needs no clearing, as it is only read where written in this frame.
`default_nettype none
module box_blur_3x3_edge_aware_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
   input  wire logic [bb3_pkg::PIX_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [39:24] out_row,
   // [49:40] out_column, [55:50] zero
   output logic [bb3_pkg::RSP_DW-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bb3_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [bb3_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bb3_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import bb3_pkg::*;

   cmd_type          cmd;
   status_type       status;
   csr_wr_type       csr_wr;
   logic [FW_W-1:0]  frame_width;
   logic [ROW_W-1:0] frame_height;

   assign csr_pready   = 1'b1;
   assign csr_wr.wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_wr.index = csr_paddr[2];
   assign csr_wr.data  = csr_pwdata;

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(frame_height);
         default:          csr_prdata = '0;
      endcase
   end

   bb3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bb3_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr       (csr_wr),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .pixel        (req_tdata),
      .rsp_data     (rsp_tdata),
      .rsp_last     (rsp_tlast)
   );
endmodule
`default_nettype wire
